### sv/smdr_pkg.sv
package smdr_pkg;

  // field widths
  localparam int X_W    = 31;
  localparam int N_W    = 18;
  localparam int D_W    = 17;
  localparam int RES_W  = 32;
  localparam int HALF_W = 15;

  // derived widths
  localparam int XHI_W     = X_W - HALF_W;
  localparam int Q_W       = 2 * HALF_W;
  localparam int PROD_LO_W = HALF_W + N_W;
  localparam int PROD_HI_W = XHI_W + N_W;
  // dividend is {0, u, low half of t}; the leading zero evens out the stage count
  localparam int DVD_W     = RES_W + HALF_W + 1;

  // divider slicing
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DVD_W / DIV_STEPS;

  typedef logic signed [X_W-1:0]   dim_t;
  typedef logic signed [N_W-1:0]   mult_t;
  typedef logic [D_W-1:0]          div_t;
  typedef logic signed [RES_W-1:0] res_t;

  // word carried through the divider stages
  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [D_W-1:0]   rem;
    logic [Q_W-1:0]   q;
    logic             qov;
    logic [RES_W-1:0] u;
    logic [D_W-1:0]   d;
    logic             neg;
  } div_word_t;

endpackage

### sv/smdr_if.sv
interface smdr_in_if;
  logic                 valid;
  logic                 ready;
  smdr_pkg::dim_t       dimension_value;
  smdr_pkg::mult_t      multiplier;
  smdr_pkg::div_t       divisor;

  modport source (output valid, dimension_value, multiplier, divisor, input ready);
  modport sink   (input valid, dimension_value, multiplier, divisor, output ready);
endinterface

interface smdr_out_if;
  logic                 valid;
  logic                 ready;
  smdr_pkg::res_t       scaled_result;
  logic                 overflow;

  modport source (output valid, scaled_result, overflow, input ready);
  modport sink   (input valid, scaled_result, overflow, output ready);
endinterface

### sv/smdr_front.sv
module smdr_front (
  input  logic                clk,
  input  logic                rst_n,
  smdr_in_if.sink             in_ch,
  output logic                out_valid,
  input  logic                out_ready,
  output smdr_pkg::div_word_t out_word
);

  logic a_v_r, b_v_r, c_v_r;
  logic a_rdy, b_rdy, c_rdy;

  logic [smdr_pkg::X_W-1:0]     mx_nxt, mx_r;
  logic [smdr_pkg::N_W-1:0]     mn_nxt, mn_r;
  logic                         a_neg_r, b_neg_r;
  logic [smdr_pkg::D_W-1:0]     a_d_r, b_d_r;
  logic [smdr_pkg::PROD_LO_W-1:0] plo_nxt;
  logic [smdr_pkg::PROD_HI_W-1:0] phi_nxt;
  logic [smdr_pkg::RES_W-1:0]   t_r, hi_r, u_nxt;
  smdr_pkg::div_word_t          word_nxt, word_r;

  // stall chain: a stage loads when empty or when the next one moves
  assign c_rdy       = !c_v_r || out_ready;
  assign b_rdy       = !b_v_r || c_rdy;
  assign a_rdy       = !a_v_r || b_rdy;
  assign in_ch.ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_ch.valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
    end
  end

  // stage a: magnitudes and result sign
  assign mx_nxt = in_ch.dimension_value[smdr_pkg::X_W-1]
                ? smdr_pkg::X_W'(0) - $unsigned(in_ch.dimension_value)
                : $unsigned(in_ch.dimension_value);
  assign mn_nxt = in_ch.multiplier[smdr_pkg::N_W-1]
                ? smdr_pkg::N_W'(0) - $unsigned(in_ch.multiplier)
                : $unsigned(in_ch.multiplier);

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      mx_r    <= mx_nxt;
      mn_r    <= mn_nxt;
      a_neg_r <= in_ch.dimension_value[smdr_pkg::X_W-1] ^ in_ch.multiplier[smdr_pkg::N_W-1];
      a_d_r   <= in_ch.divisor;
    end
  end

  // stage b: two partial products over the low 15 and high 16 bits of mx
  assign plo_nxt = smdr_pkg::PROD_LO_W'(mx_r[smdr_pkg::HALF_W-1:0])
                 * smdr_pkg::PROD_LO_W'(mn_r);
  assign phi_nxt = smdr_pkg::PROD_HI_W'(mx_r[smdr_pkg::X_W-1:smdr_pkg::HALF_W])
                 * smdr_pkg::PROD_HI_W'(mn_r);

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      t_r     <= plo_nxt[smdr_pkg::RES_W-1:0];
      hi_r    <= phi_nxt[smdr_pkg::RES_W-1:0];
      b_neg_r <= a_neg_r;
      b_d_r   <= a_d_r;
    end
  end

  // stage c: fold carry half of t into u (wraps mod 2^32), build dividend
  assign u_nxt = hi_r + smdr_pkg::RES_W'(t_r[smdr_pkg::RES_W-1:smdr_pkg::HALF_W]);

  always_comb begin
    word_nxt     = '0;
    word_nxt.dvd = {1'b0, u_nxt, t_r[smdr_pkg::HALF_W-1:0]};
    word_nxt.u   = u_nxt;
    word_nxt.d   = b_d_r;
    word_nxt.neg = b_neg_r;
  end

  always_ff @(posedge clk) begin
    if (c_rdy) word_r <= word_nxt;
  end

  assign out_valid = c_v_r;
  assign out_word  = word_r;

endmodule

### sv/smdr_div_stage.sv
module smdr_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smdr_pkg::div_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output smdr_pkg::div_word_t out_word
);

  logic                v_r;
  smdr_pkg::div_word_t word_nxt, word_r;

  assign in_ready = !v_r || out_ready;

  // restoring division, DIV_STEPS quotient bits per stage
  always_comb begin
    smdr_pkg::div_word_t w;
    logic [smdr_pkg::D_W:0] p;
    logic ge;
    w = in_word;
    for (int i = 0; i < smdr_pkg::DIV_STEPS; i++) begin
      p     = {w.rem, w.dvd[smdr_pkg::DVD_W-1]};
      w.dvd = {w.dvd[smdr_pkg::DVD_W-2:0], 1'b0};
      ge    = p >= {1'b0, w.d};
      // quotient bits above the low 30 only matter as the overflow mark
      w.qov = w.qov | w.q[smdr_pkg::Q_W-1];
      w.rem = ge ? smdr_pkg::D_W'(p - {1'b0, w.d}) : p[smdr_pkg::D_W-1:0];
      w.q   = {w.q[smdr_pkg::Q_W-2:0], ge};
    end
    word_nxt = w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) word_r <= word_nxt;
  end

  assign out_valid = v_r;
  assign out_word  = word_r;

endmodule

### sv/smdr_back.sv
module smdr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smdr_pkg::div_word_t in_word,
  smdr_out_if.source          out_ch
);

  logic r_v_r, s_v_r;
  logic r_rdy, s_rdy;

  logic [smdr_pkg::RES_W-1:0] base, mag_nxt, mag_r, res_nxt, res_r;
  logic                       up;
  logic                       ovf_r, neg_r, dz_r, ovf_out_r;

  assign s_rdy    = !s_v_r || out_ch.ready;
  assign r_rdy    = !r_v_r || s_rdy;
  assign in_ready = r_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      if (r_rdy) r_v_r <= in_valid;
      if (s_rdy) s_v_r <= r_v_r;
    end
  end

  // round: unreduced u on overflow, else the quotient; up when 2*rem >= d
  assign base    = in_word.qov ? in_word.u : smdr_pkg::RES_W'(in_word.q);
  assign up      = {in_word.rem, 1'b0} >= {1'b0, in_word.d};
  assign mag_nxt = base + smdr_pkg::RES_W'(up);

  always_ff @(posedge clk) begin
    if (r_rdy) begin
      mag_r <= mag_nxt;
      ovf_r <= in_word.qov;
      neg_r <= in_word.neg;
      dz_r  <= in_word.d == '0;
    end
  end

  // sign and zero divisor override, into the output register
  assign res_nxt = dz_r  ? '0
                 : neg_r ? smdr_pkg::RES_W'(0) - mag_r
                 : mag_r;

  always_ff @(posedge clk) begin
    if (s_rdy) begin
      res_r     <= res_nxt;
      ovf_out_r <= dz_r | ovf_r;
    end
  end

  assign out_ch.valid         = s_v_r;
  assign out_ch.scaled_result = $signed(res_r);
  assign out_ch.overflow      = ovf_out_r;

endmodule

### sv/scaled_mul_div_round.sv
// throughput: one word per cycle while out_ch does not stall
// depth: the 48-step restoring divider, 4 bits in each of 12 stages, plus abs,
//   multiply, add, round and sign stages
// reset: synchronous, active low; clears the valid bit of every stage only
// stalls on out_ch ripple back stage by stage, so empty stages still fill
module scaled_mul_div_round (
  input  logic        clk,
  input  logic        rst_n,
  smdr_in_if.sink     in_ch,
  smdr_out_if.source  out_ch
);

  logic [smdr_pkg::DIV_STAGES:0] stg_valid;
  logic [smdr_pkg::DIV_STAGES:0] stg_ready;
  smdr_pkg::div_word_t           stg_word [smdr_pkg::DIV_STAGES+1];

  // operand prep and products
  smdr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_word  (stg_word[0])
  );

  // divider pipeline
  for (genvar g = 0; g < smdr_pkg::DIV_STAGES; g++) begin : g_div
    smdr_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_word   (stg_word[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_word  (stg_word[g+1])
    );
  end

  // rounding, sign and output register
  smdr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stg_valid[smdr_pkg::DIV_STAGES]),
    .in_ready (stg_ready[smdr_pkg::DIV_STAGES]),
    .in_word  (stg_word[smdr_pkg::DIV_STAGES]),
    .out_ch   (out_ch)
  );

endmodule

### sv/smdr_checker.sv
module smdr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [smdr_pkg::RES_W-1:0] scaled_result,
  input logic                       overflow
);

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // an empty or draining output stage must let the input side move
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output stage can move");

  // without overflow the magnitude is at most 2^30
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !overflow) |->
      (scaled_result[smdr_pkg::RES_W-1 -: 2] == 2'b00 ||
       scaled_result[smdr_pkg::RES_W-1 -: 2] == 2'b11 ||
       scaled_result == smdr_pkg::RES_W'(1) << (smdr_pkg::RES_W - 2)))
    else $error("result out of range without overflow");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(scaled_result) && $stable(overflow)))
    else $error("stalled result word changed");

endmodule

bind scaled_mul_div_round smdr_checker u_smdr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .scaled_result (out_ch.scaled_result),
  .overflow      (out_ch.overflow)
);
